[rtl/olr_pkg.sv]
package olr_pkg;

	// link and slot values, wide enough for a sentinel at up to 255
	localparam int LINK_W = 8;

	localparam logic [1:0] REQ_POS_OF  = 2'd0;
	localparam logic [1:0] REQ_PROG_AT = 2'd1;
	localparam logic [1:0] REQ_MOVE    = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] profile;
		logic [6:0] prog_slot;
		logic [6:0] position;
	} req_t;

	typedef struct packed {
		logic [6:0] answer;
		logic       moved;
	} rsp_t;

endpackage

[rtl/ordered_list_reposition_top.sv]
// Per-profile program ordering held as a circular doubly linked list in two
// synchronous RAMs (next and prev links, one entry per slot, the sentinel
// at slot PROGRAMS). After reset the block runs a clearing pass that writes
// identity order into every profile, one slot a cycle; busy is high
// throughout. A request is taken when start is high and busy is low, and
// its result comes back as a single done beat that the receiver must take:
// there is no way to stall it. Every step of a walk is one RAM read, one
// link per cycle, the read address formed straight from the previous read
// data. A position lookup walks the prev links back from the program to
// the sentinel, counting steps; a program-at-position lookup walks the
// next links forward from the sentinel; a move does the backward walk,
// unlinks the program, walks forward to the new place and links it in
// there, but ends after the backward walk if the program is already in
// place. A rejected request (unused type, profile or program out of
// range) raises done at the accepting edge itself. The longest is a move
// that changes the list. busy drops in the cycle done is shown, so the
// next beat may be offered alongside the result.
module ordered_list_reposition_top #(
	parameter int PROGRAMS = 128,
	parameter int PROFILES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  olr_pkg::req_t req,
	output logic          done,
	output olr_pkg::rsp_t rsp
);

	import olr_pkg::*;

	localparam int SLOTS = PROGRAMS + 1;
	localparam int DEPTH = PROFILES * SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0]     LAST_BASE = AW'((PROFILES - 1) * SLOTS);
	localparam logic [LINK_W-1:0] SENT      = LINK_W'(PROGRAMS);
	localparam logic [LINK_W-1:0] LAST_POS  = LINK_W'(PROGRAMS - 1);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_BWALK  = 8'b0000_0100,
		ST_UNLINK = 8'b0000_1000,
		ST_FREQ   = 8'b0001_0000,
		ST_FWALK  = 8'b0010_0000,
		ST_BEFORE = 8'b0100_0000,
		ST_INS    = 8'b1000_0000
	} state_t;

	function automatic logic [LINK_W-1:0] lim(input logic [LINK_W-1:0] v);
		lim = (v > SENT) ? SENT : v;
	endfunction

	state_t            state_q;
	logic [AW-1:0]     base_q;
	logic [LINK_W-1:0] clr_slot_q;
	logic [LINK_W-1:0] cnt_q;
	logic [LINK_W-1:0] id_q;
	logic [LINK_W-1:0] pos_q;
	logic              is_move_q;
	logic [LINK_W-1:0] nx_q;
	logic [LINK_W-1:0] pv_q;
	logic [LINK_W-1:0] tgt_q;
	logic [LINK_W-1:0] before_q;
	logic              done_q;
	rsp_t              rsp_q;

	// RAM ports
	logic [LINK_W-1:0] next_rd, prev_rd;
	logic [AW-1:0]     rd_addr;
	logic              next_we, prev_we;
	logic [LINK_W-1:0] next_ws, prev_ws;   // slot written
	logic [LINK_W-1:0] next_wd, prev_wd;

	logic [AW-1:0]     in_base;
	logic [AW-1:0]     base_sel;
	logic [LINK_W-1:0] rd_slot;
	logic [LINK_W-1:0] v_next, v_prev;
	logic              prof_ok, id_ok;
	logic [LINK_W-1:0] in_id, in_pos, pos_sat;

	assign v_next  = lim(next_rd);
	assign v_prev  = lim(prev_rd);
	assign in_id   = {1'b0, req.prog_slot};
	assign in_pos  = {1'b0, req.position};
	assign pos_sat = (in_pos >= SENT) ? LAST_POS : in_pos;
	assign prof_ok = 5'(req.profile) < 5'(PROFILES);
	assign id_ok   = in_id < SENT;
	assign in_base = AW'(req.profile) * AW'(SLOTS);

	assign base_sel = (state_q == ST_IDLE) ? in_base : base_q;
	assign rd_addr  = base_sel + AW'(rd_slot);

	// read slot: the walk address comes straight off the last read
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_slot = (req.req_type == REQ_PROG_AT) ? SENT : in_id;
			ST_BWALK: rd_slot = v_prev;
			ST_FREQ:  rd_slot = SENT;
			default:  rd_slot = v_next;
		endcase
	end

	// write ports
	always_comb begin
		next_we = 1'b0;
		prev_we = 1'b0;
		next_ws = id_q;
		prev_ws = id_q;
		next_wd = tgt_q;
		prev_wd = before_q;
		case (state_q)
			ST_CLEAR: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				next_ws = clr_slot_q;
				prev_ws = clr_slot_q;
				next_wd = (clr_slot_q == SENT) ? '0 : clr_slot_q + 1'b1;
				prev_wd = (clr_slot_q == '0) ? SENT : clr_slot_q - 1'b1;
			end
			ST_UNLINK: begin
				prev_we = 1'b1;
				prev_ws = nx_q;
				prev_wd = pv_q;
				next_we = 1'b1;
				next_ws = pv_q;
				next_wd = nx_q;
			end
			ST_BEFORE: begin
				prev_we = 1'b1;
				prev_ws = tgt_q;
				prev_wd = id_q;
				next_we = 1'b1;
				next_ws = v_prev;
				next_wd = id_q;
			end
			ST_INS: begin
				prev_we = 1'b1;
				next_we = 1'b1;
			end
			default: begin
				next_we = 1'b0;
				prev_we = 1'b0;
			end
		endcase
	end

	olr_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(base_q + AW'(next_ws)),
		.wdata(next_wd),
		.raddr(rd_addr),
		.rdata(next_rd)
	);

	olr_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(base_q + AW'(prev_ws)),
		.wdata(prev_wd),
		.raddr(rd_addr),
		.rdata(prev_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			base_q     <= '0;
			clr_slot_q <= '0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			id_q       <= '0;
			pos_q      <= '0;
			is_move_q  <= 1'b0;
			nx_q       <= '0;
			pv_q       <= '0;
			tgt_q      <= '0;
			before_q   <= '0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_slot_q == SENT) begin
						clr_slot_q <= '0;
						if (base_q == LAST_BASE) begin
							state_q <= ST_IDLE;
						end else begin
							base_q <= base_q + AW'(SLOTS);
						end
					end else begin
						clr_slot_q <= clr_slot_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						base_q    <= in_base;
						id_q      <= in_id;
						pos_q     <= pos_sat;
						cnt_q     <= '0;
						is_move_q <= req.req_type == REQ_MOVE;
						if (prof_ok && req.req_type == REQ_PROG_AT) begin
							state_q <= ST_FWALK;
						end else if (prof_ok && id_ok &&
								(req.req_type == REQ_POS_OF ||
								 req.req_type == REQ_MOVE)) begin
							state_q <= ST_BWALK;
						end else begin
							done_q <= 1'b1;
							rsp_q  <= '0;
						end
					end
				end
				ST_BWALK: begin
					if (cnt_q == '0) begin
						nx_q <= v_next;
						pv_q <= v_prev;
					end
					if (v_prev == SENT || cnt_q == LAST_POS) begin
						// for a lookup, not reaching the sentinel gives the low seven bits of PROGRAMS
						if (!is_move_q) begin
							state_q      <= ST_IDLE;
							done_q       <= 1'b1;
							rsp_q.moved  <= 1'b0;
							rsp_q.answer <= (v_prev == SENT) ? cnt_q[6:0] : SENT[6:0];
						end else if (v_prev == SENT && cnt_q == pos_q) begin
							state_q      <= ST_IDLE;
							done_q       <= 1'b1;
							rsp_q.moved  <= 1'b0;
							rsp_q.answer <= pos_q[6:0];
						end else begin
							state_q <= ST_UNLINK;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UNLINK: begin
					state_q <= ST_FREQ;
				end
				ST_FREQ: begin
					cnt_q   <= '0;
					state_q <= ST_FWALK;
				end
				ST_FWALK: begin
					if (cnt_q == pos_q) begin
						tgt_q <= v_next;
						if (is_move_q) begin
							state_q <= ST_BEFORE;
						end else begin
							state_q      <= ST_IDLE;
							done_q       <= 1'b1;
							rsp_q.moved  <= 1'b0;
							rsp_q.answer <= v_next[6:0];
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BEFORE: begin
					before_q <= v_prev;
					state_q  <= ST_INS;
				end
				ST_INS: begin
					state_q      <= ST_IDLE;
					done_q       <= 1'b1;
					rsp_q.moved  <= 1'b1;
					rsp_q.answer <= pos_q[6:0];
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[rtl/olr_ram.sv]
module olr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 516
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
